// ===== rtl/core/rgbhsl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL converter package
// Types, constants and helper functions shared by the converter pipeline.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

   localparam int unsigned CH_WIDTH    = 8;
   localparam int unsigned HUE_WIDTH   = 15;
   localparam int unsigned SAT_WIDTH   = 17;
   localparam int unsigned LIGHT_WIDTH = 9;
   localparam int unsigned REQ_WIDTH   = 24;
   localparam int unsigned RSP_WIDTH   = 48;

   // One quotient bit is produced per divider stage.
   localparam int unsigned DIV_STEPS = 17;

   localparam logic [CH_WIDTH-1:0]  FULL_SCALE = 8'd255;
   localparam logic [SAT_WIDTH-1:0] SAT_ONE    = 17'd65536;
   localparam logic [HUE_WIDTH-1:0] HUE_LIMIT  = 15'd23040;

   typedef enum logic [2:0] {
      SEXT_RED_MAX_BLUE_MIN   = 3'd0,
      SEXT_GREEN_MAX_BLUE_MIN = 3'd1,
      SEXT_GREEN_MAX_RED_MIN  = 3'd2,
      SEXT_BLUE_MAX_RED_MIN   = 3'd3,
      SEXT_BLUE_MAX_GREEN_MIN = 3'd4,
      SEXT_RED_MAX_GREEN_MIN  = 3'd5
   } sextant_type;

   typedef struct packed {
      logic [CH_WIDTH-1:0] blue;
      logic [CH_WIDTH-1:0] green;
      logic [CH_WIDTH-1:0] red;
   } pixel_type;

   typedef struct packed {
      logic                gray;
      sextant_type         sext;
      logic [CH_WIDTH-1:0] lo;
      logic [CH_WIDTH-1:0] hi;
      logic [CH_WIDTH-1:0] diff;
   } prep_type;

   typedef struct packed {
      logic                 gray;
      sextant_type          sext;
      logic [LIGHT_WIDTH-1:0] light;
      logic [CH_WIDTH-1:0]  hue_div;
      logic [CH_WIDTH-1:0]  hue_rem;
      logic [DIV_STEPS-1:0] hue_acc;
      logic [CH_WIDTH-1:0]  sat_div;
      logic [CH_WIDTH-1:0]  sat_rem;
      logic [DIV_STEPS-1:0] sat_acc;
   } div_stage_type;

   typedef struct packed {
      logic [CH_WIDTH-1:0]  rem;
      logic [DIV_STEPS-1:0] acc;
   } div_step_type;

   typedef struct packed {
      logic [LIGHT_WIDTH-1:0] light;
      logic [SAT_WIDTH-1:0]   sat;
      logic [HUE_WIDTH-1:0]   hue;
   } result_type;

   // The accumulator holds the remaining dividend bits at the top and the
   // quotient bits gathered so far at the bottom.
   function automatic div_step_type div_step(input logic [CH_WIDTH-1:0]  rem,
                                             input logic [DIV_STEPS-1:0] acc,
                                             input logic [CH_WIDTH-1:0]  dvs);
      logic [CH_WIDTH:0] trial;
      logic [CH_WIDTH:0] diff;
      div_step_type      res;
      trial = {rem, acc[DIV_STEPS-1]};
      diff  = trial - {1'b0, dvs};
      if (trial >= {1'b0, dvs}) begin
         res.rem = diff[CH_WIDTH-1:0];
         res.acc = {acc[DIV_STEPS-2:0], 1'b1};
      end else begin
         res.rem = trial[CH_WIDTH-1:0];
         res.acc = {acc[DIV_STEPS-2:0], 1'b0};
      end
      return res;
   endfunction

   // Sextant start angle in degrees times 64.
   function automatic logic [HUE_WIDTH-1:0] hue_base(input sextant_type sext);
      logic [HUE_WIDTH-1:0] base;
      case (sext)
         SEXT_RED_MAX_BLUE_MIN:   base = 15'd0;
         SEXT_GREEN_MAX_BLUE_MIN: base = 15'd3840;
         SEXT_GREEN_MAX_RED_MIN:  base = 15'd7680;
         SEXT_BLUE_MAX_RED_MIN:   base = 15'd11520;
         SEXT_BLUE_MAX_GREEN_MIN: base = 15'd15360;
         SEXT_RED_MAX_GREEN_MIN:  base = 15'd19200;
         default:                 base = 15'd0;
      endcase
      return base;
   endfunction

endpackage

// ===== rtl/core/rgb_to_hsl_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL converter
// Converts one 8-bit RGB pixel per clock, unless stalled, into fixed-point
// hue, saturation and lightness, in a pipeline of one quotient bit per stage.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  req     | in        | tdata = red, green, blue (8 bits each)
//  rsp     | out       | tdata = hue (15), saturation (17), lightness (9)
//
//  One item is accepted per clock while the skid register is empty. The item
//  passes the input register, one stage of channel compares, one stage that
//  forms the dividends, seventeen divider stages of one quotient bit each,
//  and the output register.
//  Reset clears only the valid bits of the pipeline, output and skid register.
//  A stalled result is parked in a skid register; the pipeline freezes only
//  while that register is full.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0 up: red, green, blue.
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0 up: hue, saturation, lightness, zero fill.
   output logic [47:0] rsp_tdata
);

   localparam int unsigned STEPS = rgbhsl_pkg::DIV_STEPS;

   logic                    en;
   logic                    in_vld_ff;
   rgbhsl_pkg::pixel_type   in_ff;
   logic                    prep_vld_ff;
   rgbhsl_pkg::prep_type    prep_ff;
   rgbhsl_pkg::prep_type    prep_in;
   logic [STEPS:0]          div_vld_ff;
   rgbhsl_pkg::div_stage_type div_ff [STEPS+1];
   rgbhsl_pkg::div_stage_type div_in [STEPS+1];
   rgbhsl_pkg::result_type  result_in;
   rgbhsl_pkg::result_type  out_ff;
   rgbhsl_pkg::result_type  skid_ff;
   logic                    out_vld_ff;
   logic                    skid_vld_ff;

   assign en         = !skid_vld_ff;
   assign req_tready = en;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'd0, out_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         prep_vld_ff <= 1'b0;
         div_vld_ff  <= '0;
      end else if (en) begin
         in_vld_ff   <= req_tvalid;
         prep_vld_ff <= in_vld_ff;
         div_vld_ff  <= {div_vld_ff[STEPS-1:0], prep_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_ff   <= req_tdata;
         prep_ff <= prep_in;
      end
   end

   always_comb begin
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] lo;
      logic [7:0] hi;
      r  = in_ff.red;
      g  = in_ff.green;
      b  = in_ff.blue;
      lo = (r < g) ? r : g;
      lo = (lo < b) ? lo : b;
      hi = (r > g) ? r : g;
      hi = (hi > b) ? hi : b;
      prep_in.gray = (r == g) && (g == b);
      prep_in.lo   = lo;
      prep_in.hi   = hi;
      if (b == lo && r == hi) begin
         prep_in.sext = rgbhsl_pkg::SEXT_RED_MAX_BLUE_MIN;
         prep_in.diff = g - lo;
      end else if (b == lo && g == hi) begin
         prep_in.sext = rgbhsl_pkg::SEXT_GREEN_MAX_BLUE_MIN;
         prep_in.diff = hi - r;
      end else if (r == lo && g == hi) begin
         prep_in.sext = rgbhsl_pkg::SEXT_GREEN_MAX_RED_MIN;
         prep_in.diff = b - lo;
      end else if (r == lo && b == hi) begin
         prep_in.sext = rgbhsl_pkg::SEXT_BLUE_MAX_RED_MIN;
         prep_in.diff = hi - g;
      end else if (g == lo && b == hi) begin
         prep_in.sext = rgbhsl_pkg::SEXT_BLUE_MAX_GREEN_MIN;
         prep_in.diff = r - lo;
      end else begin
         prep_in.sext = rgbhsl_pkg::SEXT_RED_MAX_GREEN_MIN;
         prep_in.diff = hi - b;
      end
   end

   // The hue dividend is diff * 3840 and the saturation dividend d * 65536.
   always_comb begin
      logic [7:0]  d;
      logic [8:0]  sum;
      logic [8:0]  sum_gap;
      logic [19:0] hue_num;
      d       = prep_ff.hi - prep_ff.lo;
      sum     = {1'b0, prep_ff.lo} + {1'b0, prep_ff.hi};
      sum_gap = (sum >= {1'b0, rgbhsl_pkg::FULL_SCALE}) ?
                (sum - {1'b0, rgbhsl_pkg::FULL_SCALE}) :
                ({1'b0, rgbhsl_pkg::FULL_SCALE} - sum);
      hue_num = {prep_ff.diff, 12'd0} - {4'd0, prep_ff.diff, 8'd0};
      div_in[0].gray    = prep_ff.gray;
      div_in[0].sext    = prep_ff.sext;
      div_in[0].light   = sum;
      div_in[0].hue_div = d;
      div_in[0].hue_rem = {5'd0, hue_num[19:17]};
      div_in[0].hue_acc = hue_num[16:0];
      div_in[0].sat_div = rgbhsl_pkg::FULL_SCALE - sum_gap[7:0];
      div_in[0].sat_rem = {1'b0, d[7:1]};
      div_in[0].sat_acc = {d[0], 16'd0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff[0] <= div_in[0];
      end
   end

   for (genvar k = 1; k <= STEPS; k++) begin : g_div
      rgbhsl_pkg::div_step_type hue_step;
      rgbhsl_pkg::div_step_type sat_step;

      always_comb begin
         hue_step = rgbhsl_pkg::div_step(div_ff[k-1].hue_rem, div_ff[k-1].hue_acc,
                                         div_ff[k-1].hue_div);
         sat_step = rgbhsl_pkg::div_step(div_ff[k-1].sat_rem, div_ff[k-1].sat_acc,
                                         div_ff[k-1].sat_div);
         div_in[k]         = div_ff[k-1];
         div_in[k].hue_rem = hue_step.rem;
         div_in[k].hue_acc = hue_step.acc;
         div_in[k].sat_rem = sat_step.rem;
         div_in[k].sat_acc = sat_step.acc;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   always_comb begin
      result_in.light = div_ff[STEPS].light;
      if (div_ff[STEPS].gray) begin
         result_in.hue = '0;
         result_in.sat = '0;
      end else begin
         result_in.hue = rgbhsl_pkg::hue_base(div_ff[STEPS].sext) +
                         {3'd0, div_ff[STEPS].hue_acc[11:0]};
         result_in.sat = div_ff[STEPS].sat_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || rsp_tready) begin
         out_vld_ff  <= skid_vld_ff || div_vld_ff[STEPS];
         skid_vld_ff <= 1'b0;
      end else if (en && div_vld_ff[STEPS]) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || rsp_tready) begin
         out_ff <= skid_vld_ff ? skid_ff : result_in;
      end else if (en && div_vld_ff[STEPS]) begin
         skid_ff <= result_in;
      end
   end

`ifndef SYNTHESIS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid register holds an item while the output is empty");

   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (out_ff.sat <= rgbhsl_pkg::SAT_ONE))
      else $error("saturation above one");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (out_ff.hue < rgbhsl_pkg::HUE_LIMIT))
      else $error("hue at or above 360 degrees");

   a_gray_hue: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_ff.sat == '0) |-> (out_ff.hue == '0))
      else $error("zero saturation with nonzero hue");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL converter testbench
// Streams pixels into the converter and checks each hue, saturation and
// lightness result against a predictor. The pixels are a directed set of
// gray, tied and extreme colors, then random colors. Both sides idle at
// random, and the receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned PIXELS       = 450;
   localparam int unsigned IDLE_LIMIT   = 1000;
   localparam int unsigned DRAIN_CYCLES = 30;
   localparam int unsigned HOLD_CYCLES  = 80;

   class hsl_scoreboard;
      rgbhsl_pkg::result_type hsl_due[$];
      int unsigned mismatches = 0;

      static function rgbhsl_pkg::result_type predict_hsl(
            logic [rgbhsl_pkg::CH_WIDTH-1:0] red,
            logic [rgbhsl_pkg::CH_WIDTH-1:0] green,
            logic [rgbhsl_pkg::CH_WIDTH-1:0] blue);
         logic [rgbhsl_pkg::CH_WIDTH-1:0]    lo;
         logic [rgbhsl_pkg::CH_WIDTH-1:0]    hi;
         logic [rgbhsl_pkg::CH_WIDTH-1:0]    span;
         logic [rgbhsl_pkg::CH_WIDTH-1:0]    part;
         logic [rgbhsl_pkg::LIGHT_WIDTH-1:0] sum;
         logic [rgbhsl_pkg::LIGHT_WIDTH-1:0] sum_gap;
         logic [rgbhsl_pkg::LIGHT_WIDTH-1:0] den;
         logic [19:0]                        hue_frac;
         logic [23:0]                        sat_full;
         rgbhsl_pkg::sextant_type            sext;
         rgbhsl_pkg::result_type             res;
         res = '0;
         if (red == green && green == blue) begin
            res.light = {red, 1'b0};
            return res;
         end
         lo = red;
         if (green < lo) lo = green;
         if (blue < lo) lo = blue;
         hi = red;
         if (green > hi) hi = green;
         if (blue > hi) hi = blue;
         span = hi - lo;
         // The first matching sextant wins when two channels tie.
         if (blue == lo && red == hi) begin
            sext = rgbhsl_pkg::SEXT_RED_MAX_BLUE_MIN;
            part = green - lo;
         end else if (blue == lo && green == hi) begin
            sext = rgbhsl_pkg::SEXT_GREEN_MAX_BLUE_MIN;
            part = hi - red;
         end else if (red == lo && green == hi) begin
            sext = rgbhsl_pkg::SEXT_GREEN_MAX_RED_MIN;
            part = blue - lo;
         end else if (red == lo && blue == hi) begin
            sext = rgbhsl_pkg::SEXT_BLUE_MAX_RED_MIN;
            part = hi - green;
         end else if (green == lo && blue == hi) begin
            sext = rgbhsl_pkg::SEXT_BLUE_MAX_GREEN_MIN;
            part = red - lo;
         end else begin
            sext = rgbhsl_pkg::SEXT_RED_MAX_GREEN_MIN;
            part = hi - blue;
         end
         hue_frac = ({12'd0, part} * 20'd3840) / {12'd0, span};
         res.hue = rgbhsl_pkg::HUE_WIDTH'(int'(sext) * 3840) +
                   hue_frac[rgbhsl_pkg::HUE_WIDTH-1:0];
         sum = {1'b0, lo} + {1'b0, hi};
         sum_gap = (sum >= 9'd255) ? sum - 9'd255 : 9'd255 - sum;
         den = 9'd255 - sum_gap;
         sat_full = {span, 16'd0} / {15'd0, den};
         res.sat = sat_full[rgbhsl_pkg::SAT_WIDTH-1:0];
         res.light = sum;
         return res;
      endfunction

      task report(string msg);
         mismatches++;
         $display("MISMATCH: %s", msg);
      endtask

      function void note_pixel(logic [rgbhsl_pkg::CH_WIDTH-1:0] red,
                               logic [rgbhsl_pkg::CH_WIDTH-1:0] green,
                               logic [rgbhsl_pkg::CH_WIDTH-1:0] blue);
         hsl_due.push_back(predict_hsl(red, green, blue));
      endfunction

      task check_result(logic [rgbhsl_pkg::RSP_WIDTH-1:0] data);
         rgbhsl_pkg::result_type want;
         rgbhsl_pkg::result_type got;
         if (hsl_due.size() == 0) begin
            report($sformatf("result %h arrived with no pixel pending", data));
            return;
         end
         want = hsl_due.pop_front();
         got = data[rgbhsl_pkg::LIGHT_WIDTH+rgbhsl_pkg::SAT_WIDTH+rgbhsl_pkg::HUE_WIDTH-1:0];
         if (got.hue != want.hue)
            report($sformatf("hue %0d, expected %0d", got.hue, want.hue));
         if (got.sat != want.sat)
            report($sformatf("saturation %0d, expected %0d", got.sat, want.sat));
         if (got.light != want.light)
            report($sformatf("lightness %0d, expected %0d", got.light, want.light));
         if (data[rgbhsl_pkg::RSP_WIDTH-1:
                  rgbhsl_pkg::LIGHT_WIDTH+rgbhsl_pkg::SAT_WIDTH+rgbhsl_pkg::HUE_WIDTH] != '0)
            report($sformatf("fill bits not zero in %h", data));
      endtask
   endclass

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [rgbhsl_pkg::REQ_WIDTH-1:0] req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [rgbhsl_pkg::RSP_WIDTH-1:0] rsp_tdata;

   logic        steady       = 1'b0;
   logic        hold_request = 1'b0;
   int unsigned idle_cycles  = 0;

   hsl_scoreboard board = new;

   rgb_to_hsl_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("rgb_to_hsl_converter test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task send_pixel(input logic [rgbhsl_pkg::CH_WIDTH-1:0] red,
                   input logic [rgbhsl_pkg::CH_WIDTH-1:0] green,
                   input logic [rgbhsl_pkg::CH_WIDTH-1:0] blue);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {blue, green, red};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_pixel(red, green, blue);
   endtask

   initial begin
      int unsigned stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            stall = HOLD_CYCLES;
         end else if (steady) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 4);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         board.check_result(rsp_tdata);
         @(negedge clock);
      end
   end

   initial begin
      logic [rgbhsl_pkg::CH_WIDTH-1:0] red;
      logic [rgbhsl_pkg::CH_WIDTH-1:0] green;
      logic [rgbhsl_pkg::CH_WIDTH-1:0] blue;
      logic [rgbhsl_pkg::CH_WIDTH-1:0] pick [6];
      int unsigned                     kind;
      pick = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Gray, every sextant, ties between channels and full-scale colors.
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd128, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd0,   8'd128, 8'd255);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd128, 8'd0,   8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd255, 8'd0,   8'd128);
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd0,   8'd0,   8'd1);
      send_pixel(8'd254, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd254, 8'd254);
      send_pixel(8'd1,   8'd2,   8'd3);
      send_pixel(8'd200, 8'd100, 8'd50);
      send_pixel(8'd255, 8'd128, 8'd0);
      send_pixel(8'd127, 8'd128, 8'd128);
      send_pixel(8'd10,  8'd250, 8'd90);

      for (int n = 0; n < PIXELS; n++) begin
         steady = (n >= 150 && n < 230) || (n >= 330 && n < 370);
         if (n == 160) hold_request = 1'b1;
         red   = rgbhsl_pkg::CH_WIDTH'($urandom_range(0, 255));
         green = rgbhsl_pkg::CH_WIDTH'($urandom_range(0, 255));
         blue  = rgbhsl_pkg::CH_WIDTH'($urandom_range(0, 255));
         kind  = $urandom_range(0, 19);
         if (kind < 2) begin
            green = red;
            blue  = red;
         end else if (kind < 5) begin
            case ($urandom_range(0, 2))
               0: green = red;
               1: blue  = green;
               default: red = blue;
            endcase
         end else if (kind < 8) begin
            if ($urandom_range(0, 1)) red   = pick[$urandom_range(0, 5)];
            if ($urandom_range(0, 1)) green = pick[$urandom_range(0, 5)];
            if ($urandom_range(0, 1)) blue  = pick[$urandom_range(0, 5)];
         end
         send_pixel(red, green, blue);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
      steady = 1'b0;

      while (board.hsl_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("rgb_to_hsl_converter test passed");
      end else begin
         $display("rgb_to_hsl_converter test failed");
      end
      $finish;
   end

endmodule
